[src/assert_macros.svh]
// Concurrent assertion helper macros for the LED animation sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on clk outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/ledseq_pkg.sv]
// Types, constants and LED mask helpers for the LED animation sequencer
`default_nettype none

package ledseq_pkg;

  localparam int unsigned NUM_LEDS = 23;

  typedef logic [NUM_LEDS-1:0] led_vec_t;
  typedef logic [3:0]          mode_t;

  typedef struct packed {
    logic  kind;
    mode_t new_mode;
  } in_item_t;

  typedef struct packed {
    led_vec_t led_pattern;
    mode_t    current_mode;
  } out_item_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  localparam mode_t MODE_TWOSIDE = 4'd0;
  localparam mode_t MODE_SCAN    = 4'd1;
  localparam mode_t MODE_LOADING = 4'd2;
  localparam mode_t MODE_SNAKE   = 4'd3;
  localparam mode_t MODE_BLINK   = 4'd4;
  localparam mode_t MODE_BATTERY = 4'd5;
  localparam mode_t MODE_FULL_ON = 4'd6;
  localparam mode_t MODE_OFF     = 4'd7;
  localparam mode_t MODE_RUNNING = 4'd8;

  localparam logic CFG_BATTERY_LEVEL = 1'b0;
  localparam logic CFG_RETURN_MODE   = 1'b1;

  localparam led_vec_t ALL_LEDS = '1;

  localparam logic [4:0]  FAST_TICKS     = 5'd20;
  localparam logic [5:0]  LOAD_TICKS     = 6'd50;
  localparam logic [7:0]  BLINK_TICKS    = 8'd200;
  localparam logic [9:0]  BATTERY_TICKS  = 10'd1000;
  localparam logic [11:0] RUN_ON_TICKS   = 12'd30;
  localparam logic [11:0] RUN_OFF_TICKS  = 12'd3000;
  localparam logic [6:0]  TWOSIDE_STEPS  = 7'd74;
  localparam logic [6:0]  SNAKE_STEPS    = 7'd81;
  localparam logic [3:0]  TWOSIDE_TOP    = 4'd13;
  localparam logic [4:0]  TWOSIDE_MIRROR = 5'd24;
  localparam logic [4:0]  SCAN_WRAP      = 5'd18;
  localparam logic [4:0]  LOAD_EMPTY     = 5'd24;
  localparam logic [4:0]  LOAD_START     = 5'd23;
  localparam logic [4:0]  SNAKE_TOP      = 5'd27;
  localparam logic [4:0]  LED_COUNT      = 5'd23;
  localparam logic [4:0]  RUN_LO         = 5'd10;
  localparam logic [4:0]  RUN_HI         = 5'd14;

  // single LED n, 1..23; anything else lights nothing
  function automatic led_vec_t led_mask(input logic [4:0] n);
    led_vec_t m;
    m = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      m[i] = (n == 5'(i + 1));
    end
    return m;
  endfunction

  // LEDs lo..hi inclusive
  function automatic led_vec_t led_range(input logic [4:0] lo, input logic [4:0] hi);
    led_vec_t m;
    m = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      m[i] = (5'(i + 1) >= lo) && (5'(i + 1) <= hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/led_animation_sequencer.sv]
// LED animation sequencer: nine modes over 23 latched LEDs, one result per transfer
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall   | in_item_t  (kind, new_mode)
//   out_    | output    | out_valid/out_stall | out_item_t (led_pattern, current_mode)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One transfer per cycle sustained while the output is not stalled; an accepted input is held
// in the input register, then all mode state and the output register update together on advance.
// rst_n is synchronous: clears the pipeline valids, mode state and LEDs.
// A held result stalls the input register, which in turn raises in_stall.
`default_nettype none

module led_animation_sequencer
  import ledseq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [4:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       adv;
  logic       in_take;

  logic [4:0] battery_level_r;
  mode_t      return_mode_r;

  led_vec_t   led_r, led_nxt;
  mode_t      mode_r, mode_nxt;
  logic [4:0] ts_div_r, ts_div_nxt;
  logic [6:0] ts_steps_r, ts_steps_nxt;
  logic [3:0] ts_pos_r, ts_pos_nxt;
  logic       ts_up_r, ts_up_nxt;
  logic [4:0] scan_div_r, scan_div_nxt;
  logic [4:0] scan_pos_r, scan_pos_nxt;
  logic [5:0] load_div_r, load_div_nxt;
  logic [4:0] load_pos_r, load_pos_nxt;
  logic [4:0] snake_div_r, snake_div_nxt;
  logic [6:0] snake_steps_r, snake_steps_nxt;
  logic [4:0] snake_head_r, snake_head_nxt;
  logic [7:0] blink_div_r, blink_div_nxt;
  logic       blink_phase_r, blink_phase_nxt;
  logic [9:0] batt_cnt_r, batt_cnt_nxt;
  logic [11:0] run_cnt_r, run_cnt_nxt;
  logic       run_phase_r, run_phase_nxt;

  // two-side bounce worked out in two steps, as up then down in the same step
  logic [3:0] ts_p1, ts_p2;
  logic       ts_u1, ts_u2;
  logic [4:0] batt_lvl;
  logic [4:0] snake_m1;
  logic [4:0] load_m1;
  logic [4:0] scan_p1;
  led_vec_t   snake_bits;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r.led_pattern  <= led_nxt;
      out_item_r.current_mode <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      battery_level_r <= '0;
      return_mode_r   <= MODE_TWOSIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BATTERY_LEVEL: battery_level_r <= cfg_wdata;
        CFG_RETURN_MODE:   return_mode_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ts_p1 = ts_up_r ? ts_pos_r + 4'd1 : ts_pos_r;
    ts_u1 = ts_up_r && (ts_p1 != TWOSIDE_TOP);
    ts_p2 = ts_u1 ? ts_p1 : ts_p1 - 4'd1;
    ts_u2 = ts_u1 || (ts_p2 == 4'd0);
    batt_lvl = (battery_level_r > LED_COUNT) ? LED_COUNT : battery_level_r;
    snake_m1 = snake_head_r - 5'd1;
    load_m1  = load_pos_r - 5'd1;
    scan_p1  = scan_pos_r + 5'd1;
    snake_bits = '0;
    for (int i = 0; i < 5; i++) begin
      if (snake_head_r >= 5'(i)) begin
        snake_bits = snake_bits | led_mask(snake_head_r - 5'(i));
      end
    end
  end

  always_comb begin
    led_nxt         = led_r;
    mode_nxt        = mode_r;
    ts_div_nxt      = ts_div_r;
    ts_steps_nxt    = ts_steps_r;
    ts_pos_nxt      = ts_pos_r;
    ts_up_nxt       = ts_up_r;
    scan_div_nxt    = scan_div_r;
    scan_pos_nxt    = scan_pos_r;
    load_div_nxt    = load_div_r;
    load_pos_nxt    = load_pos_r;
    snake_div_nxt   = snake_div_r;
    snake_steps_nxt = snake_steps_r;
    snake_head_nxt  = snake_head_r;
    blink_div_nxt   = blink_div_r;
    blink_phase_nxt = blink_phase_r;
    batt_cnt_nxt    = batt_cnt_r;
    run_cnt_nxt     = run_cnt_r;
    run_phase_nxt   = run_phase_r;
    if (s1_item_r.kind == KIND_SET) begin
      mode_nxt = s1_item_r.new_mode;
    end else begin
      case (mode_r)
        MODE_TWOSIDE: begin
          ts_div_nxt = ts_div_r + 5'd1;
          if (ts_div_nxt >= FAST_TICKS) begin
            ts_div_nxt   = '0;
            ts_pos_nxt   = ts_p2;
            ts_up_nxt    = ts_u2;
            led_nxt      = led_mask({1'b0, ts_p2}) | led_mask(TWOSIDE_MIRROR - {1'b0, ts_p2});
            ts_steps_nxt = ts_steps_r + 7'd1;
            if (ts_steps_nxt >= TWOSIDE_STEPS) begin
              ts_steps_nxt = '0;
              mode_nxt     = MODE_LOADING;
            end
          end
        end
        MODE_SCAN: begin
          scan_div_nxt = scan_div_r + 5'd1;
          if (scan_div_nxt >= FAST_TICKS) begin
            scan_div_nxt = '0;
            led_nxt      = led_mask(scan_pos_r);
            scan_pos_nxt = (scan_p1 == SCAN_WRAP) ? 5'd1 : scan_p1;
          end
        end
        MODE_LOADING: begin
          load_div_nxt = load_div_r + 6'd1;
          if (load_div_nxt >= LOAD_TICKS) begin
            load_div_nxt = '0;
            led_nxt      = led_range(load_pos_r, LED_COUNT);
            load_pos_nxt = (load_m1 == 5'd0) ? LOAD_EMPTY : load_m1;
          end
        end
        MODE_SNAKE: begin
          snake_div_nxt = snake_div_r + 5'd1;
          if (snake_div_nxt >= FAST_TICKS) begin
            snake_div_nxt   = '0;
            led_nxt         = snake_bits;
            snake_head_nxt  = (snake_m1 == 5'd0) ? SNAKE_TOP : snake_m1;
            snake_steps_nxt = snake_steps_r + 7'd1;
            if (snake_steps_nxt >= SNAKE_STEPS) begin
              snake_steps_nxt = '0;
              led_nxt         = '0;
              mode_nxt        = MODE_RUNNING;
            end
          end
        end
        MODE_BLINK: begin
          blink_div_nxt = blink_div_r + 8'd1;
          if (blink_div_nxt >= BLINK_TICKS) begin
            blink_div_nxt   = '0;
            led_nxt         = blink_phase_r ? ALL_LEDS : '0;
            blink_phase_nxt = !blink_phase_r;
          end
        end
        MODE_BATTERY: begin
          led_nxt      = led_r | led_range(5'd1, batt_lvl);
          batt_cnt_nxt = batt_cnt_r + 10'd1;
          if (batt_cnt_nxt >= BATTERY_TICKS) begin
            batt_cnt_nxt = '0;
            led_nxt      = '0;
            mode_nxt     = return_mode_r;
          end
        end
        MODE_FULL_ON: led_nxt = ALL_LEDS;
        MODE_OFF:     led_nxt = '0;
        MODE_RUNNING: begin
          run_cnt_nxt = run_cnt_r + 12'd1;
          if (run_phase_r) begin
            if (run_cnt_nxt >= RUN_ON_TICKS) begin
              led_nxt       = '0;
              run_phase_nxt = 1'b0;
              run_cnt_nxt   = '0;
            end
          end else if (run_cnt_nxt >= RUN_OFF_TICKS) begin
            run_cnt_nxt   = '0;
            led_nxt       = led_r | led_range(RUN_LO, RUN_HI);
            run_phase_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r         <= '0;
      mode_r        <= MODE_TWOSIDE;
      ts_div_r      <= '0;
      ts_steps_r    <= '0;
      ts_pos_r      <= '0;
      ts_up_r       <= 1'b1;
      scan_div_r    <= '0;
      scan_pos_r    <= 5'd1;
      load_div_r    <= '0;
      load_pos_r    <= LOAD_START;
      snake_div_r   <= '0;
      snake_steps_r <= '0;
      snake_head_r  <= SNAKE_TOP;
      blink_div_r   <= '0;
      blink_phase_r <= 1'b1;
      batt_cnt_r    <= '0;
      run_cnt_r     <= '0;
      run_phase_r   <= 1'b1;
    end else if (adv) begin
      led_r         <= led_nxt;
      mode_r        <= mode_nxt;
      ts_div_r      <= ts_div_nxt;
      ts_steps_r    <= ts_steps_nxt;
      ts_pos_r      <= ts_pos_nxt;
      ts_up_r       <= ts_up_nxt;
      scan_div_r    <= scan_div_nxt;
      scan_pos_r    <= scan_pos_nxt;
      load_div_r    <= load_div_nxt;
      load_pos_r    <= load_pos_nxt;
      snake_div_r   <= snake_div_nxt;
      snake_steps_r <= snake_steps_nxt;
      snake_head_r  <= snake_head_nxt;
      blink_div_r   <= blink_div_nxt;
      blink_phase_r <= blink_phase_nxt;
      batt_cnt_r    <= batt_cnt_nxt;
      run_cnt_r     <= run_cnt_nxt;
      run_phase_r   <= run_phase_nxt;
    end
  end

  `ASSERT_CLK(a_adv_gives_result, adv |=> out_valid_r, "transfer advanced but no result held")
  `ASSERT_CLK(a_result_matches_state, adv |=> out_item_r == {led_r, mode_r}, "stale result")
  `ASSERT_CLK(a_state_holds_idle, !adv |=> $stable({mode_r, led_r}), "state moved when idle")
  `ASSERT_NEVER(a_twoside_range, ts_pos_r > TWOSIDE_TOP, "two-side position out of range")

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the LED animation sequencer: directed table, then random mode/tick traffic
`timescale 1ns / 100ps

module tb_top;
  import ledseq_pkg::*;

  localparam int FAST_DIV     = 20;
  localparam int LOAD_DIV     = 50;
  localparam int BLINK_DIV    = 200;
  localparam int BATTERY_LEN  = 1000;
  localparam int RUN_ON_LEN   = 30;
  localparam int RUN_OFF_LEN  = 3000;
  localparam int TWOSIDE_LEN  = 74;
  localparam int SNAKE_LEN    = 81;
  localparam int TWOSIDE_PEAK = 13;
  localparam int SCAN_WRAP_AT = 18;
  localparam int SNAKE_START  = 27;
  localparam int SNAKE_BODY   = 5;
  localparam int LED_TOTAL    = 23;
  localparam int LOAD_FIRST   = 23;
  localparam int LOAD_NONE    = 24;
  localparam int RUN_LO_LED   = 10;
  localparam int RUN_HI_LED   = 14;
  localparam int PLAN_LEN     = 23;
  localparam int PHASE_ITEMS  = 460;
  localparam int CYCLE_LIMIT  = 400000;

  localparam mode_t    MODE_BAD_LO = 4'd9;
  localparam mode_t    MODE_BAD_HI = 4'd15;
  localparam led_vec_t LEDS_OFF    = '0;

  typedef struct packed {
    logic     kind;
    mode_t    mode;
    logic     typed;
    led_vec_t leds;
    mode_t    cur;
  } plan_row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_BATTERY_LEVEL;
  logic [4:0] cfg_wdata = '0;

  led_animation_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the sequencer state
  led_vec_t    shadow_leds;
  mode_t       shadow_mode;
  logic [4:0]  ts_div;
  logic [6:0]  ts_steps;
  logic [3:0]  ts_pos;
  logic        ts_up;
  logic [4:0]  sc_div;
  logic [4:0]  sc_pos;
  logic [5:0]  ld_div;
  logic [4:0]  ld_pos;
  logic [4:0]  sn_div;
  logic [6:0]  sn_steps;
  logic [4:0]  sn_head;
  logic [7:0]  bl_div;
  logic        bl_phase;
  logic [9:0]  bat_cnt;
  logic [11:0] run_cnt;
  logic        run_phase;
  logic [4:0]  bat_level_r;
  mode_t       ret_mode_r;

  out_item_t   due_frames[$];
  out_item_t   due;
  int          mismatches = 0;
  int          burst_left;
  int          seg_left;
  int unsigned cycles = 0;
  int          stall_style = 0;
  int          stall_left = 0;
  int          stall_tick = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{KIND_TICK, MODE_TWOSIDE, 1'b1, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_FULL_ON, 1'b1, LEDS_OFF, MODE_FULL_ON},
    '{KIND_TICK, MODE_BAD_HI,  1'b1, ALL_LEDS, MODE_FULL_ON},
    '{KIND_SET,  MODE_OFF,     1'b1, ALL_LEDS, MODE_OFF},
    '{KIND_TICK, MODE_OFF,     1'b1, LEDS_OFF, MODE_OFF},
    '{KIND_SET,  MODE_BATTERY, 1'b1, LEDS_OFF, MODE_BATTERY},
    '{KIND_TICK, MODE_BATTERY, 1'b1, ALL_LEDS, MODE_BATTERY},
    '{KIND_SET,  MODE_SCAN,    1'b1, ALL_LEDS, MODE_SCAN},
    '{KIND_TICK, MODE_BAD_LO,  1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_LOADING, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_TWOSIDE, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_SNAKE,   1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_RUNNING, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_BLINK,   1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_FULL_ON, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_RUNNING, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_SCAN,    1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_BAD_LO,  1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_SNAKE,   1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_BAD_HI,  1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_BLINK,   1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_SET,  MODE_TWOSIDE, 1'b0, LEDS_OFF, MODE_TWOSIDE},
    '{KIND_TICK, MODE_BAD_HI,  1'b0, LEDS_OFF, MODE_TWOSIDE}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic led_vec_t lamp(input int n);
    led_vec_t m;
    m = '0;
    if (n >= 1 && n <= LED_TOTAL) m[n-1] = 1'b1;
    return m;
  endfunction

  function automatic led_vec_t lamps(input int lo, input int hi);
    led_vec_t m;
    m = '0;
    for (int n = lo; n <= hi; n++) m |= lamp(n);
    return m;
  endfunction

  task automatic clear_shadow();
    shadow_leds = '0;
    shadow_mode = MODE_TWOSIDE;
    ts_div = '0;
    ts_steps = '0;
    ts_pos = '0;
    ts_up = 1'b1;
    sc_div = '0;
    sc_pos = 5'd1;
    ld_div = '0;
    ld_pos = 5'(LOAD_FIRST);
    sn_div = '0;
    sn_steps = '0;
    sn_head = 5'(SNAKE_START);
    bl_div = '0;
    bl_phase = 1'b1;
    bat_cnt = '0;
    run_cnt = '0;
    run_phase = 1'b1;
    bat_level_r = '0;
    ret_mode_r = MODE_TWOSIDE;
  endtask

  task automatic advance_tick();
    int lvl;
    case (shadow_mode)
      MODE_TWOSIDE: begin
        ts_div = ts_div + 1'b1;
        if (ts_div >= FAST_DIV) begin
          ts_div = '0;
          if (ts_up) begin
            ts_pos = ts_pos + 1'b1;
            if (ts_pos == TWOSIDE_PEAK) ts_up = 1'b0;
          end
          if (!ts_up) begin
            ts_pos = ts_pos - 1'b1;
            if (ts_pos == 0) ts_up = 1'b1;
          end
          shadow_leds = lamp(int'(ts_pos)) | lamp(LED_TOTAL + 1 - int'(ts_pos));
          ts_steps = ts_steps + 1'b1;
          if (ts_steps >= TWOSIDE_LEN) begin
            ts_steps = '0;
            shadow_mode = MODE_LOADING;
          end
        end
      end
      MODE_SCAN: begin
        sc_div = sc_div + 1'b1;
        if (sc_div >= FAST_DIV) begin
          sc_div = '0;
          shadow_leds = lamp(int'(sc_pos));
          sc_pos = sc_pos + 1'b1;
          if (sc_pos == SCAN_WRAP_AT) sc_pos = 5'd1;
        end
      end
      MODE_LOADING: begin
        ld_div = ld_div + 1'b1;
        if (ld_div >= LOAD_DIV) begin
          ld_div = '0;
          shadow_leds = lamps(int'(ld_pos), LED_TOTAL);
          ld_pos = ld_pos - 1'b1;
          if (ld_pos == 0) ld_pos = 5'(LOAD_NONE);
        end
      end
      MODE_SNAKE: begin
        sn_div = sn_div + 1'b1;
        if (sn_div >= FAST_DIV) begin
          sn_div = '0;
          shadow_leds = '0;
          for (int i = 0; i < SNAKE_BODY; i++)
            if (int'(sn_head) >= i) shadow_leds |= lamp(int'(sn_head) - i);
          sn_head = sn_head - 1'b1;
          if (sn_head == 0) sn_head = 5'(SNAKE_START);
          sn_steps = sn_steps + 1'b1;
          if (sn_steps >= SNAKE_LEN) begin
            sn_steps = '0;
            shadow_leds = '0;
            shadow_mode = MODE_RUNNING;
          end
        end
      end
      MODE_BLINK: begin
        bl_div = bl_div + 1'b1;
        if (bl_div >= BLINK_DIV) begin
          bl_div = '0;
          shadow_leds = bl_phase ? ALL_LEDS : LEDS_OFF;
          bl_phase = ~bl_phase;
        end
      end
      MODE_BATTERY: begin
        lvl = (int'(bat_level_r) > LED_TOTAL) ? LED_TOTAL : int'(bat_level_r);
        shadow_leds |= lamps(1, lvl);
        bat_cnt = bat_cnt + 1'b1;
        if (bat_cnt >= BATTERY_LEN) begin
          bat_cnt = '0;
          shadow_leds = '0;
          shadow_mode = ret_mode_r;
        end
      end
      MODE_FULL_ON: shadow_leds = ALL_LEDS;
      MODE_OFF:     shadow_leds = LEDS_OFF;
      MODE_RUNNING: begin
        run_cnt = run_cnt + 1'b1;
        if (run_phase) begin
          if (run_cnt >= RUN_ON_LEN) begin
            shadow_leds = '0;
            run_phase = 1'b0;
            run_cnt = '0;
          end
        end else if (run_cnt >= RUN_OFF_LEN) begin
          run_cnt = '0;
          shadow_leds |= lamps(RUN_LO_LED, RUN_HI_LED);
          run_phase = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t frame;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.kind == KIND_SET) shadow_mode = it.new_mode;
    else advance_tick();
    frame.led_pattern = shadow_leds;
    frame.current_mode = shadow_mode;
    due_frames.push_back(typed ? want : frame);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [4:0] level, input logic [4:0] ret_raw);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BATTERY_LEVEL;
    cfg_wdata <= level;
    @(posedge clk);
    bat_level_r = level;
    cfg_index <= CFG_RETURN_MODE;
    cfg_wdata <= ret_raw;
    @(posedge clk);
    ret_mode_r = ret_raw[3:0];
    cfg_we <= 1'b0;
  endtask

  // mostly "set mode, then a run of ticks"; some stray mode codes and broken runs
  task automatic make_item(output in_item_t it);
    int pick;
    mode_t code;
    if (seg_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) code = mode_t'($urandom_range(0, 15));
      else if (pick < 43) code = MODE_BATTERY;
      else code = mode_t'($urandom_range(MODE_TWOSIDE, MODE_RUNNING));
      it.kind = KIND_SET;
      it.new_mode = code;
      case (code)
        MODE_BATTERY:
          seg_left = (bat_cnt >= 700) ? BATTERY_LEN - int'(bat_cnt) + $urandom_range(0, 20)
                                      : $urandom_range(20, 150);
        MODE_BLINK:   seg_left = $urandom_range(20, 220);
        MODE_RUNNING: seg_left = $urandom_range(5, 60);
        default:      seg_left = $urandom_range(1, 60);
      endcase
    end else if ($urandom_range(0, 39) == 0) begin
      it.kind = KIND_SET;
      it.new_mode = mode_t'($urandom_range(0, 15));
    end else begin
      it.kind = KIND_TICK;
      it.new_mode = mode_t'($urandom_range(0, 15));
      seg_left--;
    end
  endtask

  initial begin
    in_item_t  it;
    out_item_t want;
    clear_shadow();
    burst_left = 0;
    seg_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cfg(5'd31, {1'b0, MODE_SCAN});
    for (int n = 0; n < PLAN_LEN; n++) begin
      it.kind = plan[n].kind;
      it.new_mode = plan[n].mode;
      want.led_pattern = plan[n].leds;
      want.current_mode = plan[n].cur;
      send(it, plan[n].typed, want);
      pace();
    end
    want = '0;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: write_cfg(5'd0, {1'($urandom_range(0, 1)), MODE_TWOSIDE});
        1: write_cfg(5'd23, {1'($urandom_range(0, 1)), MODE_BAD_HI});
        2: write_cfg(5'd31, 5'($urandom_range(0, 31)));
        default: write_cfg(5'($urandom_range(0, 31)),
                           {1'b0, mode_t'($urandom_range(MODE_TWOSIDE, MODE_RUNNING))});
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_item(it);
        send(it, 1'b0, want);
        pace();
      end
    end
    drain();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, got %06h mode %0d",
                 $time, out_item.led_pattern, out_item.current_mode);
      end else begin
        due = due_frames.pop_front();
        if (out_item.led_pattern !== due.led_pattern) begin
          mismatches++;
          $display("%0t: led_pattern expected %06h, got %06h",
                   $time, due.led_pattern, out_item.led_pattern);
        end
        if (out_item.current_mode !== due.current_mode) begin
          mismatches++;
          $display("%0t: current_mode expected %0d, got %0d",
                   $time, due.current_mode, out_item.current_mode);
        end
      end
    end
  end

  // receiver back-pressure: one of four stall patterns, picked anew at random
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
